@@ src/m3inv_pkg.sv @@
// Shared types and constants of the 3x3 matrix inverse.
package m3inv_pkg;

  // element format: signed fixed point, Q16.16
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;

  typedef struct packed {
    elem_t m00;
    elem_t m01;
    elem_t m02;
    elem_t m10;
    elem_t m11;
    elem_t m12;
    elem_t m20;
    elem_t m21;
    elem_t m22;
  } in_t;

  typedef struct packed {
    elem_t r00;
    elem_t r01;
    elem_t r02;
    elem_t r10;
    elem_t r11;
    elem_t r12;
    elem_t r20;
    elem_t r21;
    elem_t r22;
    logic  singular;
    logic  overflow;
  } out_t;

  // adjugate element k (row-major) = m[A]*m[B] - m[C]*m[D]
  localparam int COF_IDX [9][4] = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

endpackage

@@ src/matrix3x3_inverse_top.sv @@
// Elements in and out are Q16.16; every input transfer yields one result.
// Throughput: one matrix per cycle while the output is not stalled; each quotient bit of the nine dividers is
// one pipeline stage, all sharing the registered determinant magnitude.
// A stall holds only full stages, so bubbles are squeezed out under stall.
// Reset (rst_n low, synchronous) clears all stage valid bits; data registers
// are not reset.
module matrix3x3_inverse_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  m3inv_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output m3inv_pkg::out_t   out_data
);
  import m3inv_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int PW    = 2 * W;          // element product
  localparam int CW    = 2 * W + 1;      // signed cofactor
  localparam int AW    = 2 * W;          // cofactor magnitude
  localparam int HW    = 2 * W + 1;      // determinant partial product
  localparam int DTW   = 3 * W + 2;      // signed determinant
  localparam int DW    = 3 * W;          // determinant magnitude
  localparam int NW    = AW + 2 * F;     // scaled numerator
  localparam int R0W   = NW - W;         // numerator head before bit steps
  localparam int CMPW  = (R0W > DW) ? R0W : DW;
  localparam int ST_DIV0 = 7;
  localparam int ST_RND  = ST_DIV0 + W;
  localparam int ST_OUT  = ST_RND + 1;
  localparam int NST     = ST_OUT + 1;

  // stage valid bits and per-stage advance enables
  logic [NST-1:0] v_r, v_nxt, en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    for (int i = 0; i < NST; i++) begin
      if (en[i]) begin
        v_nxt[i] = (i == 0) ? in_valid : v_r[i-1];
      end else begin
        v_nxt[i] = v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NST-1];

  // unpack input matrix
  elem_t m [9];
  always_comb begin
    m[0] = in_data.m00; m[1] = in_data.m01; m[2] = in_data.m02;
    m[3] = in_data.m10; m[4] = in_data.m11; m[5] = in_data.m12;
    m[6] = in_data.m20; m[7] = in_data.m21; m[8] = in_data.m22;
  end

  // stage 0: the eighteen element products
  logic signed [PW-1:0] p_r [18];
  elem_t                m0_r [3];
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < 9; c++) begin
        p_r[2*c]   <= m[COF_IDX[c][0]] * m[COF_IDX[c][1]];
        p_r[2*c+1] <= m[COF_IDX[c][2]] * m[COF_IDX[c][3]];
      end
      for (int j = 0; j < 3; j++) m0_r[j] <= m[j];
    end
  end

  // stage 1: cofactors
  logic signed [CW-1:0] cof1_r [9];
  elem_t                m1_r [3];
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int c = 0; c < 9; c++) begin
        cof1_r[c] <= CW'(p_r[2*c]) - CW'(p_r[2*c+1]);
      end
      for (int j = 0; j < 3; j++) m1_r[j] <= m0_r[j];
    end
  end

  // stage 2: first-row expansion, cofactor cut into low and high halves
  logic signed [HW-1:0] dlo_r [3];
  logic signed [HW-1:0] dhi_r [3];
  logic signed [CW-1:0] cof2_r [9];
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int j = 0; j < 3; j++) begin
        dlo_r[j] <= m1_r[j] * $signed({1'b0, cof1_r[3*j][W-1:0]});
        dhi_r[j] <= m1_r[j] * $signed(cof1_r[3*j][CW-1:W]);
      end
      cof2_r <= cof1_r;
    end
  end

  // stage 3: recombine halves
  logic signed [DTW-1:0] term_r [3];
  logic signed [CW-1:0]  cof3_r [9];
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int j = 0; j < 3; j++) begin
        term_r[j] <= (DTW'(dhi_r[j]) <<< W) + DTW'(dlo_r[j]);
      end
      cof3_r <= cof2_r;
    end
  end

  // stage 4: determinant
  logic signed [DTW-1:0] det_r;
  logic signed [CW-1:0]  cof4_r [9];
  always_ff @(posedge clk) begin
    if (en[4]) begin
      det_r  <= term_r[0] + term_r[1] + term_r[2];
      cof4_r <= cof3_r;
    end
  end

  // stage 5: magnitudes and signs
  logic [DW-1:0] dmag_r;
  logic [AW-1:0] amag_r [9];
  logic [8:0]    neg5_r;
  logic          sing5_r;
  always_ff @(posedge clk) begin
    if (en[5]) begin
      dmag_r  <= det_r[DTW-1] ? DW'(-det_r) : DW'(det_r);
      sing5_r <= (det_r == '0);
      for (int c = 0; c < 9; c++) begin
        amag_r[c] <= cof4_r[c][CW-1] ? AW'(-cof4_r[c]) : AW'(cof4_r[c]);
        neg5_r[c] <= cof4_r[c][CW-1] ^ det_r[DTW-1];
      end
    end
  end

  // divider pipeline: index k holds the state after k quotient bits
  logic [DW-1:0] rem_r  [W+1][9];
  logic [W-1:0]  nlo_r  [W+1][9];
  logic [W-1:0]  q_r    [W+1][9];
  logic [DW-1:0] dv_r   [W+1];
  logic [8:0]    big_r  [W+1];
  logic [8:0]    neg_r  [W+1];
  logic          sing_r [W+1];

  // stage 6: quotient of 2^W or more saturates outright
  logic [NW-1:0]  num [9];
  logic [R0W-1:0] head [9];
  always_comb begin
    for (int c = 0; c < 9; c++) begin
      num[c]  = {amag_r[c], (2*F)'(0)};
      head[c] = num[c][NW-1:W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int c = 0; c < 9; c++) begin
        rem_r[0][c]  <= DW'(CMPW'(head[c]));
        nlo_r[0][c]  <= num[c][W-1:0];
        q_r[0][c]    <= '0;
        big_r[0][c]  <= (CMPW'(head[c]) >= CMPW'(dmag_r));
      end
      dv_r[0]   <= dmag_r;
      neg_r[0]  <= neg5_r;
      sing_r[0] <= sing5_r;
    end
  end

  // one restoring quotient bit per stage
  for (genvar k = 0; k < W; k++) begin : g_div
    logic [DW:0] trial [9];
    logic [8:0]  ge;
    always_comb begin
      for (int c = 0; c < 9; c++) begin
        trial[c] = {rem_r[k][c], nlo_r[k][c][W-1]};
        ge[c]    = (trial[c] >= {1'b0, dv_r[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_DIV0+k]) begin
        for (int c = 0; c < 9; c++) begin
          rem_r[k+1][c] <= ge[c] ? DW'(trial[c] - {1'b0, dv_r[k]}) : trial[c][DW-1:0];
          nlo_r[k+1][c] <= nlo_r[k][c] << 1;
          q_r[k+1][c]   <= {q_r[k][c][W-2:0], ge[c]};
        end
        dv_r[k+1]   <= dv_r[k];
        big_r[k+1]  <= big_r[k];
        neg_r[k+1]  <= neg_r[k];
        sing_r[k+1] <= sing_r[k];
      end
    end
  end

  // round to nearest, ties away from zero
  logic [W:0] qf_r [9];
  logic [8:0] bigr_r, negr_r;
  logic       singr_r;
  logic [DW:0] rtrial [9];
  always_comb begin
    for (int c = 0; c < 9; c++) rtrial[c] = {rem_r[W][c], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en[ST_RND]) begin
      for (int c = 0; c < 9; c++) begin
        qf_r[c] <= (W+1)'(q_r[W][c]) + (W+1)'(rtrial[c] >= {1'b0, dv_r[W]});
      end
      bigr_r  <= big_r[W];
      negr_r  <= neg_r[W];
      singr_r <= sing_r[W];
    end
  end

  // saturate, apply sign, singular override
  logic [W:0]  lim [9];
  logic [W:0]  mag [9];
  logic [W:0]  sgn [9];
  logic [8:0]  sat;
  elem_t       res [9];
  out_t        out_nxt;
  always_comb begin
    for (int c = 0; c < 9; c++) begin
      lim[c] = {2'b00, {(W-1){1'b1}}} + (W+1)'(negr_r[c]);
      sat[c] = bigr_r[c] || (qf_r[c] > lim[c]);
      mag[c] = sat[c] ? lim[c] : qf_r[c];
      sgn[c] = negr_r[c] ? ((W+1)'(0) - mag[c]) : mag[c];
      res[c] = singr_r ? '0 : $signed(sgn[c][W-1:0]);
    end
    out_nxt.r00 = res[0]; out_nxt.r01 = res[1]; out_nxt.r02 = res[2];
    out_nxt.r10 = res[3]; out_nxt.r11 = res[4]; out_nxt.r12 = res[5];
    out_nxt.r20 = res[6]; out_nxt.r21 = res[7]; out_nxt.r22 = res[8];
    out_nxt.singular = singr_r;
    out_nxt.overflow = !singr_r && (|sat);
  end

  out_t out_r;
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // a singular result never reports overflow
  a_sing_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.singular && out_data.overflow))
    else $error("singular result flagged overflow");

  // a singular result carries an all-zero matrix
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.singular) |->
      (out_data.r00 == '0 && out_data.r01 == '0 && out_data.r02 == '0 &&
       out_data.r10 == '0 && out_data.r11 == '0 && out_data.r12 == '0 &&
       out_data.r20 == '0 && out_data.r21 == '0 && out_data.r22 == '0))
    else $error("singular result has nonzero element");

  // input is held off only when every stage is full and the output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&v_r) && out_stall))
    else $error("input stalled with room in the pipeline");

  // a result blocked at the output leaves the stage behind it intact
  a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && v_r[NST-2]) |=> v_r[NST-2])
    else $error("item lost behind stalled output");

endmodule

@@ dv/matrix3x3_inverse_top_tb.sv @@
// Testbench for the 3x3 fixed-point matrix inverse: exact predictor, scoreboard, random traffic.
module matrix3x3_inverse_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import m3inv_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int XW = 4 * W + 4;  // holds det (3W) and adj << 2F with margin

  typedef logic signed [XW-1:0] xint_t;

  // exact adjugate inverse with round-half-away and saturation
  function automatic out_t inverse_of(in_t mi);
    xint_t m [9];
    xint_t adj [9];
    xint_t det, num, dmag, nmag, q, r, lim;
    out_t o;
    logic neg;
    m[0] = mi.m00; m[1] = mi.m01; m[2] = mi.m02;
    m[3] = mi.m10; m[4] = mi.m11; m[5] = mi.m12;
    m[6] = mi.m20; m[7] = mi.m21; m[8] = mi.m22;
    for (int k = 0; k < 9; k++) begin
      adj[k] = m[COF_IDX[k][0]] * m[COF_IDX[k][1]] - m[COF_IDX[k][2]] * m[COF_IDX[k][3]];
    end
    det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
    o = '0;
    if (det == 0) begin
      o.singular = 1'b1;
      return o;
    end
    dmag = det < 0 ? -det : det;
    for (int k = 0; k < 9; k++) begin
      num  = adj[k] <<< (2 * FB);
      nmag = num < 0 ? -num : num;
      q = nmag / dmag;
      r = nmag % dmag;
      if (2 * r >= dmag) q = q + 1;
      neg = (q != 0) && ((adj[k] < 0) != (det < 0));
      lim = (xint_t'(1) <<< (W - 1)) - 1 + (neg ? 1 : 0);
      if (q > lim) begin
        q = lim;
        o.overflow = 1'b1;
      end
      if (neg) q = -q;
      case (k)
        0: o.r00 = q[W-1:0];
        1: o.r01 = q[W-1:0];
        2: o.r02 = q[W-1:0];
        3: o.r10 = q[W-1:0];
        4: o.r11 = q[W-1:0];
        5: o.r12 = q[W-1:0];
        6: o.r20 = q[W-1:0];
        7: o.r21 = q[W-1:0];
        default: o.r22 = q[W-1:0];
      endcase
    end
    return o;
  endfunction

  class inverse_scoreboard;
    out_t pending [$];
    int errors;

    function void note_input(in_t mi);
      pending.push_back(inverse_of(mi));
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.r00 != exp_r.r00) begin $error("r00 exp %h got %h", exp_r.r00, got.r00); errors++; end
      if (got.r01 != exp_r.r01) begin $error("r01 exp %h got %h", exp_r.r01, got.r01); errors++; end
      if (got.r02 != exp_r.r02) begin $error("r02 exp %h got %h", exp_r.r02, got.r02); errors++; end
      if (got.r10 != exp_r.r10) begin $error("r10 exp %h got %h", exp_r.r10, got.r10); errors++; end
      if (got.r11 != exp_r.r11) begin $error("r11 exp %h got %h", exp_r.r11, got.r11); errors++; end
      if (got.r12 != exp_r.r12) begin $error("r12 exp %h got %h", exp_r.r12, got.r12); errors++; end
      if (got.r20 != exp_r.r20) begin $error("r20 exp %h got %h", exp_r.r20, got.r20); errors++; end
      if (got.r21 != exp_r.r21) begin $error("r21 exp %h got %h", exp_r.r21, got.r21); errors++; end
      if (got.r22 != exp_r.r22) begin $error("r22 exp %h got %h", exp_r.r22, got.r22); errors++; end
      if (got.singular != exp_r.singular) begin
        $error("singular exp %b got %b", exp_r.singular, got.singular); errors++;
      end
      if (got.overflow != exp_r.overflow) begin
        $error("overflow exp %b got %b", exp_r.overflow, got.overflow); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  inverse_scoreboard sb;

  always #5 clk = ~clk;

  matrix3x3_inverse_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // receiver: random stall, plus a counted long hold-off when requested
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic elem_t rand_elem();
    case ($urandom_range(9))
      0: return elem_t'(32'h8000_0000);
      1: return elem_t'(32'h7fff_ffff);
      2: return '0;
      3, 4: return elem_t'($urandom());
      5: return elem_t'($urandom_range(32'h2_0000)) - elem_t'(32'h1_0000);
      6: return elem_t'($urandom_range(255)) - elem_t'(128);
      default: return elem_t'($urandom_range(32'h40_0000)) - elem_t'(32'h20_0000);
    endcase
  endfunction

  function automatic in_t rand_matrix();
    in_t mi;
    mi = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
          rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    // some singular matrices: repeat a row, a scaled copy, or a zero column
    case ($urandom_range(9))
      0: begin mi.m20 = mi.m00; mi.m21 = mi.m01; mi.m22 = mi.m02; end
      1: begin mi.m10 = mi.m00 <<< 1; mi.m11 = mi.m01 <<< 1; mi.m12 = mi.m02 <<< 1; end
      2: begin mi.m02 = '0; mi.m12 = '0; mi.m22 = '0; end
      default: ;
    endcase
    return mi;
  endfunction

  // one input transfer, with optional idle cycles first; valid stays up
  // until the next call drives new data or drops it
  task automatic send_matrix(in_t mi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= mi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(mi);
  endtask

  task automatic run_phase(int n, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_matrix(rand_matrix());
  endtask

  initial begin
    in_t d;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity, scaled, extremes, singular, saturation, negatives
    d = '0; d.m00 = 32'h1_0000; d.m11 = 32'h1_0000; d.m22 = 32'h1_0000; send_matrix(d);
    d = '0; d.m00 = 32'h2_0000; d.m11 = -32'sh4_0000; d.m22 = 32'h8000; send_matrix(d);
    d = '0; send_matrix(d);
    d = '1; send_matrix(d);
    d = {9{elem_t'(32'h7fff_ffff)}}; send_matrix(d);
    d = {9{elem_t'(32'h8000_0000)}}; send_matrix(d);
    d = '0; d.m00 = 32'h1; d.m11 = 32'h1; d.m22 = 32'h1; send_matrix(d);
    d = '0; d.m00 = 32'h7fff_ffff; d.m11 = 32'h7fff_ffff; d.m22 = 32'h7fff_ffff; send_matrix(d);
    d = '0; d.m00 = 32'h8000_0000; d.m11 = 32'h8000_0000; d.m22 = 32'h8000_0000; send_matrix(d);
    d = '0; d.m02 = 32'h1_0000; d.m11 = 32'h1_0000; d.m20 = 32'h1_0000; send_matrix(d);
    d = '0; d.m00 = 32'h3_0000; d.m01 = 32'h1_0000; d.m10 = 32'h1_0000;
    d.m11 = 32'h3_0000; d.m22 = 32'h1_0000; send_matrix(d);
    d = '0; d.m00 = 32'h3; d.m11 = 32'h1_0000; d.m22 = 32'h1_0000; send_matrix(d);
    d = '0; d.m00 = 32'h7fff_ffff; d.m01 = 32'h8000_0000; d.m10 = 32'h8000_0000;
    d.m11 = 32'h7fff_ffff; d.m22 = 32'h1; send_matrix(d);
    d = '0; d.m00 = -32'sh1_0000; d.m11 = 32'h1_0000; d.m22 = 32'h1_0000;
    d.m01 = 32'h5555; d.m12 = -32'sh1234; send_matrix(d);

    run_phase(170, 0, 0);
    run_phase(120, 73, 0);
    run_phase(120, 0, 73);
    run_phase(120, 38, 38);

    // long hold-off while the sender keeps offering
    recv_stall_pct = 0;
    send_idle_pct  = 0;
    hold_cycles = 200;
    for (int i = 0; i < 110; i++) send_matrix(rand_matrix());
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) $display("matrix3x3_inverse_top_tb OK");
    else $display("matrix3x3_inverse_top_tb NOT OK");
    $finish;
  end

  initial begin
    #5ms;
    $display("matrix3x3_inverse_top_tb NOT OK");
    $finish;
  end
endmodule

@@ sim.f @@
src/m3inv_pkg.sv
src/matrix3x3_inverse_top.sv
dv/matrix3x3_inverse_top_tb.sv
